>>> rtl/fm_voice_pitch_update_defines.svh
// ----------------------------------------------------------------------------
// FM voice pitch update: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FM_VOICE_PITCH_UPDATE_DEFINES_SVH
`define FM_VOICE_PITCH_UPDATE_DEFINES_SVH

// Checks a consequence in the same cycle; uses clk and rst_n of the caller.
`define FVPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the next cycle.
`define FVPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fvpu_pkg.sv
// ----------------------------------------------------------------------------
// FM voice pitch update: package
// Constants, the F-number table, the queued item type and the note
// conversion shared by the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fvpu_pkg;

    localparam int NUM_CHANNELS = 9;
    localparam int SLOT_COUNT   = 2 * NUM_CHANNELS;
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int CH_W         = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam int WORD_W  = 16;
    localparam int DX_W    = 18;
    localparam int DIFF_W  = 19;
    localparam int MAG_W   = 17;
    localparam int PROD_W  = DIFF_W + MAG_W + 1;
    localparam int BEND_SHIFT = 13;

    localparam int FLAG_ARP = 0;
    localparam int FLAG_VIB = 1;
    localparam int FLAG_ENV = 2;

    localparam logic [1:0] VOICE_IDLE     = 2'd0;
    localparam logic [1:0] VOICE_RELEASED = 2'd2;

    localparam logic [7:0] REG_A_BASE     = 8'hA0;
    localparam logic [7:0] REG_B_BASE     = 8'hB0;
    localparam logic [7:0] SHADOW_A_RESET = 8'h00;
    localparam logic [7:0] SHADOW_B_RESET = 8'h01;

    localparam logic [7:0] SEMIS        = 8'd12;
    localparam logic [7:0] DIV12_MUL    = 8'd171;
    localparam int         DIV12_SHIFT  = 11;
    localparam logic signed [7:0] IDX_LOW  = -8'sd24;
    localparam logic signed [7:0] IDX_HIGH = 8'sd35;
    localparam int TABLE_DEPTH = 60;

    localparam logic [9:0] FNUM_TABLE [TABLE_DEPTH] = '{
        10'h015, 10'h017, 10'h018, 10'h019, 10'h01B, 10'h01D,
        10'h01E, 10'h020, 10'h022, 10'h024, 10'h026, 10'h028,
        10'h02B, 10'h02D, 10'h030, 10'h033, 10'h036, 10'h039,
        10'h03D, 10'h040, 10'h044, 10'h048, 10'h04C, 10'h051,
        10'h056, 10'h05B, 10'h060, 10'h066, 10'h06C, 10'h072,
        10'h079, 10'h080, 10'h088, 10'h090, 10'h099, 10'h0A2,
        10'h0AB, 10'h0B6, 10'h0C0, 10'h0CC, 10'h0D8, 10'h0E5,
        10'h0F2, 10'h101, 10'h110, 10'h120, 10'h132, 10'h144,
        10'h157, 10'h16B, 10'h181, 10'h198, 10'h1B0, 10'h1CA,
        10'h1E5, 10'h202, 10'h220, 10'h241, 10'h263, 10'h287
    };

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [1:0]        voice_state;
        logic [DX_W-1:0]   dx;
        logic [WORD_W-1:0] target;
        logic              bend_down;
        logic [MAG_W-1:0]  bend_mag;
        logic [7:0]        fine_tune;
    } item_t;

    // Block is note/12 through a reciprocal multiply, exact for 8-bit notes.
    function automatic logic [WORD_W-1:0] note_word(input logic [7:0] note,
                                                    input logic [7:0] offset);
        logic [15:0]       recip;
        logic [4:0]        block;
        logic [3:0]        semi;
        logic signed [7:0] idx;
        logic signed [7:0] clamped;
        logic [5:0]        tidx;
        recip   = 16'(note) * 16'(DIV12_MUL);
        block   = recip[DIV12_SHIFT +: 5];
        semi    = 4'(note - 8'({3'b000, block} * SEMIS));
        idx     = $signed(8'({4'b0000, semi} + offset));
        if (idx < IDX_LOW) begin
            clamped = IDX_LOW;
        end else if (idx > IDX_HIGH) begin
            clamped = IDX_HIGH;
        end else begin
            clamped = idx;
        end
        tidx = 6'(clamped - IDX_LOW);
        return {1'b0, block, FNUM_TABLE[tidx]};
    endfunction

endpackage

>>> rtl/fvpu_in_if.sv
// ----------------------------------------------------------------------------
// FM voice pitch update: update channel
// Valid/ready channel that carries one per-tick voice update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fvpu_in_if;
    logic              valid;
    logic              ready;
    logic [3:0]        channel;
    logic [15:0]       base_pack;
    logic [7:0]        note;
    logic signed [7:0] arp_offset;
    logic [2:0]        mode_flags;
    logic signed [15:0] vibrato;
    logic signed [15:0] env_level;
    logic signed [15:0] bend;
    logic signed [7:0] bend_range;
    logic signed [7:0] fine_tune;
    logic [1:0]        voice_state;

    modport source (
        output valid, channel, base_pack, note, arp_offset, mode_flags,
               vibrato, env_level, bend, bend_range, fine_tune, voice_state,
        input  ready
    );

    modport sink (
        input  valid, channel, base_pack, note, arp_offset, mode_flags,
               vibrato, env_level, bend, bend_range, fine_tune, voice_state,
        output ready
    );
endinterface

>>> rtl/fvpu_out_if.sv
// ----------------------------------------------------------------------------
// FM voice pitch update: register write channel
// Valid/ready channel that carries one chip register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fvpu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_value;
    logic        write_valid;
    logic [15:0] tuned_pack;
    logic        last;

    modport source (
        output valid, reg_addr, reg_value, write_valid, tuned_pack, last,
        input  ready
    );

    modport sink (
        input  valid, reg_addr, reg_value, write_valid, tuned_pack, last,
        output ready
    );
endinterface

>>> rtl/fvpu_front.sv
// ----------------------------------------------------------------------------
// FM voice pitch update: front part
// Accepts updates, drops idle voices and unknown channels, converts notes
// to packed words and registers the prepared item for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvpu_front (
    input  logic            clk,
    input  logic            rst_n,
    fvpu_in_if.sink         upd,
    output logic            item_valid,
    input  logic            item_ready,
    output fvpu_pkg::item_t item
);
    import fvpu_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    item_t             item_reg;
    item_t             item_calc;
    logic              keep;
    logic              take;
    logic [WORD_W-1:0] arp_word;
    logic [7:0]        target_off;
    logic [DX_W-1:0]   start;
    logic [DX_W-1:0]   vib_term;
    logic [DX_W-1:0]   env_term;

    assign upd.ready = !valid_reg || item_ready;
    assign take      = upd.valid && upd.ready;
    assign keep      = (upd.voice_state != VOICE_IDLE)
                    && (upd.channel < CH_W'(NUM_CHANNELS));

    always_comb
    begin
        arp_word   = note_word(8'(upd.note + upd.arp_offset), 8'd0);
        target_off = upd.bend[15] ? 8'(8'd0 - upd.bend_range) : upd.bend_range;
        start      = upd.mode_flags[FLAG_ARP]
                   ? {{(DX_W-WORD_W){arp_word[WORD_W-1]}}, arp_word}
                   : {{(DX_W-WORD_W){upd.base_pack[WORD_W-1]}}, upd.base_pack};
        vib_term   = upd.mode_flags[FLAG_VIB]
                   ? {{(DX_W-16){upd.vibrato[15]}}, upd.vibrato} : '0;
        env_term   = upd.mode_flags[FLAG_ENV]
                   ? {{(DX_W-16){upd.env_level[15]}}, upd.env_level} : '0;

        item_calc.channel     = upd.channel;
        item_calc.voice_state = upd.voice_state;
        item_calc.dx          = start + vib_term + env_term;
        item_calc.target      = note_word(upd.note, target_off);
        item_calc.bend_down   = upd.bend[15];
        item_calc.bend_mag    = upd.bend[15]
                              ? MAG_W'(17'd0 - {upd.bend[15], upd.bend})
                              : {1'b0, upd.bend};
        item_calc.fine_tune   = upd.fine_tune;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = keep;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && keep) begin
            item_reg <= item_calc;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/fvpu_fifo.sv
// ----------------------------------------------------------------------------
// FM voice pitch update: item queue
// Short register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvpu_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  fvpu_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output fvpu_pkg::item_t pop_item
);
    import fvpu_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/fvpu_back.sv
// ----------------------------------------------------------------------------
// FM voice pitch update: back part
// Bend interpolation in a difference, multiply and sum pipeline, then the
// two register writes per item with the shadow compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvpu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  fvpu_pkg::item_t pop_item,
    fvpu_out_if.source      wr
);
    import fvpu_pkg::*;

    // Difference stage.
    logic                d_valid_reg;
    logic                d_valid_next;
    logic                d_take;
    logic [DIFF_W-1:0]   d_diff_reg;
    logic [WORD_W-1:0]   d_dx_reg;
    logic                d_down_reg;
    logic [MAG_W-1:0]    d_mag_reg;
    logic [7:0]          d_fine_reg;
    logic [CH_W-1:0]     d_ch_reg;
    logic [1:0]          d_state_reg;
    logic [DIFF_W-1:0]   dx_ext;
    logic [DIFF_W-1:0]   tgt_ext;

    // Product stage.
    logic                p_valid_reg;
    logic                p_valid_next;
    logic                p_take;
    logic signed [PROD_W-1:0] product;
    logic [WORD_W-1:0]   p_step_reg;
    logic [WORD_W-1:0]   p_dx_reg;
    logic                p_down_reg;
    logic [7:0]          p_fine_reg;
    logic [CH_W-1:0]     p_ch_reg;
    logic [1:0]          p_state_reg;

    // Emit stage.
    logic                e_valid_reg;
    logic                e_valid_next;
    logic                e_last_reg;
    logic                e_last_next;
    logic                e_take;
    logic [WORD_W-1:0]   e_word_reg;
    logic [CH_W-1:0]     e_ch_reg;
    logic [1:0]          e_state_reg;
    logic [WORD_W-1:0]   word_calc;
    logic [WORD_W-1:0]   fine_ext;

    // Output register and shadow.
    logic                o_valid_reg;
    logic                o_valid_next;
    logic                out_load;
    logic [7:0]          o_addr_reg;
    logic [7:0]          o_value_reg;
    logic                o_diff_reg;
    logic [WORD_W-1:0]   o_word_reg;
    logic                o_last_reg;
    logic [7:0]          shadow_reg [SLOT_COUNT];
    logic [SLOT_W-1:0]   slot;
    logic [7:0]          value;
    logic [7:0]          addr;
    logic [2:0]          key_bits;
    logic                diff;

    assign out_load  = e_valid_reg && (!o_valid_reg || wr.ready);
    assign e_take    = !e_valid_reg || (out_load && e_last_reg);
    assign p_take    = !p_valid_reg || e_take;
    assign d_take    = !d_valid_reg || p_take;
    assign pop_ready = d_take;

    assign dx_ext  = {pop_item.dx[DX_W-1], pop_item.dx};
    assign tgt_ext = {{(DIFF_W-WORD_W){pop_item.target[WORD_W-1]}}, pop_item.target};

    assign product = PROD_W'($signed(d_diff_reg)) * PROD_W'($signed({1'b0, d_mag_reg}));

    assign fine_ext  = {{(WORD_W-8){p_fine_reg[7]}}, p_fine_reg};
    assign word_calc = p_down_reg ? p_dx_reg - p_step_reg + fine_ext
                                  : p_dx_reg + p_step_reg + fine_ext;

    always_comb
    begin
        key_bits = 3'(3'(VOICE_RELEASED) - {1'b0, e_state_reg});
        slot     = e_last_reg ? SLOT_W'(NUM_CHANNELS) + SLOT_W'(e_ch_reg) : SLOT_W'(e_ch_reg);
        addr     = e_last_reg ? REG_B_BASE + {4'b0000, e_ch_reg}
                              : REG_A_BASE + {4'b0000, e_ch_reg};
        value    = e_last_reg ? ({key_bits, 5'b00000} | e_word_reg[15:8]) : e_word_reg[7:0];
        diff     = shadow_reg[slot] != value;
    end

    always_comb
    begin
        d_valid_next = d_valid_reg;
        p_valid_next = p_valid_reg;
        e_valid_next = e_valid_reg;
        e_last_next  = e_last_reg;
        o_valid_next = o_valid_reg;
        if (d_take) begin
            d_valid_next = pop_valid;
        end
        if (p_take) begin
            p_valid_next = d_valid_reg;
        end
        if (e_take) begin
            e_valid_next = p_valid_reg;
            e_last_next  = 1'b0;
        end else if (out_load) begin
            e_last_next  = 1'b1;
        end
        if (out_load) begin
            o_valid_next = 1'b1;
        end else if (wr.ready) begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            d_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            e_last_reg  <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            d_valid_reg <= d_valid_next;
            p_valid_reg <= p_valid_next;
            e_valid_reg <= e_valid_next;
            e_last_reg  <= e_last_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                shadow_reg[i] <= (i < NUM_CHANNELS) ? SHADOW_A_RESET : SHADOW_B_RESET;
            end
        end else if (out_load && diff) begin
            shadow_reg[slot] <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_take && pop_valid) begin
            d_diff_reg  <= pop_item.bend_down ? dx_ext - tgt_ext : tgt_ext - dx_ext;
            d_dx_reg    <= pop_item.dx[WORD_W-1:0];
            d_down_reg  <= pop_item.bend_down;
            d_mag_reg   <= pop_item.bend_mag;
            d_fine_reg  <= pop_item.fine_tune;
            d_ch_reg    <= pop_item.channel;
            d_state_reg <= pop_item.voice_state;
        end
        if (p_take && d_valid_reg) begin
            p_step_reg  <= product[BEND_SHIFT +: WORD_W];
            p_dx_reg    <= d_dx_reg;
            p_down_reg  <= d_down_reg;
            p_fine_reg  <= d_fine_reg;
            p_ch_reg    <= d_ch_reg;
            p_state_reg <= d_state_reg;
        end
        if (e_take && p_valid_reg) begin
            e_word_reg  <= word_calc;
            e_ch_reg    <= p_ch_reg;
            e_state_reg <= p_state_reg;
        end
        if (out_load) begin
            o_addr_reg  <= addr;
            o_value_reg <= value;
            o_diff_reg  <= diff;
            o_word_reg  <= e_word_reg;
            o_last_reg  <= e_last_reg;
        end
    end

    assign wr.valid       = o_valid_reg;
    assign wr.reg_addr    = o_addr_reg;
    assign wr.reg_value   = o_value_reg;
    assign wr.write_valid = o_diff_reg;
    assign wr.tuned_pack  = o_word_reg;
    assign wr.last        = o_last_reg;

endmodule

>>> rtl/fm_voice_pitch_update.sv
// ----------------------------------------------------------------------------
// FM voice pitch update: top level
// Per-tick pitch update of one FM voice, giving the A0 and B0 register
// writes of its channel, each flagged against a per-channel shadow.
//
//   Channel  Direction  Contents
//   upd      sink       one voice update (channel, words, offsets, state)
//   wr       source     one register write, two per update, last on B0
//
// The two writes of an update leave one per cycle while wr.ready is high.
// After the update transfer the item passes the front register, the queue,
// then the difference, multiply, emit and output registers, each of which
// can hold it under back-pressure, before the first write is presented.
// Idle voices and channels beyond the last give no writes.
// The queue lets updates enter while the write port is stalled.
// Reset clears the valid flags and queue pointers and loads the shadow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fm_voice_pitch_update_defines.svh"

module fm_voice_pitch_update (
    input  logic       clk,
    input  logic       rst_n,
    fvpu_in_if.sink    upd,
    fvpu_out_if.source wr
);
    import fvpu_pkg::*;

    logic  front_valid;
    logic  front_ready;
    item_t front_item;
    logic  queue_valid;
    logic  queue_ready;
    item_t queue_item;

    fvpu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (upd),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    fvpu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    fvpu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (queue_valid),
        .pop_ready (queue_ready),
        .pop_item  (queue_item),
        .wr        (wr)
    );

    `FVPU_ASSERT_NEXT(a_b_follows_a,
        wr.valid && wr.ready && !wr.last,
        wr.valid && wr.last,
        "B0 write did not follow A0 write")
    `FVPU_ASSERT_NEXT(a_pair_match,
        wr.valid && wr.ready && !wr.last,
        (wr.reg_addr[3:0] == $past(wr.reg_addr[3:0]))
            && (wr.tuned_pack == $past(wr.tuned_pack)),
        "write pair differs in channel or word")
    `FVPU_ASSERT_NOW(a_addr_bank,
        wr.valid,
        wr.last ? (wr.reg_addr[7:4] == REG_B_BASE[7:4])
                : (wr.reg_addr[7:4] == REG_A_BASE[7:4]),
        "register bank does not match write order")
    `FVPU_ASSERT_NEXT(a_idle_dropped,
        upd.valid && upd.ready && (upd.voice_state == VOICE_IDLE),
        !front_valid,
        "idle voice update was queued")

endmodule
